@@ sv/ccq_pkg.sv @@
// Shared types, constants and helper functions for the coalescing command queue.
package ccq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int STAMP_WIDTH = 32;
  localparam int MAX_REPEAT = 1000;
  localparam int TYPE_W = 4;
  localparam int ARG_W = 63;
  localparam int REP_W = 10;
  localparam int TAG_W = 16;
  localparam int OUTC_W = 4;

  localparam logic [REP_W-1:0] MAX_REP = REP_W'(MAX_REPEAT);

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_POP = 2'd1;
  localparam logic [1:0] CMD_BEGIN = 2'd2;
  localparam logic [1:0] CMD_END = 2'd3;

  localparam logic [TYPE_W-1:0] T_OPEN = 4'd0;
  localparam logic [TYPE_W-1:0] T_PLAY = 4'd1;
  localparam logic [TYPE_W-1:0] T_PAUSE = 4'd2;
  localparam logic [TYPE_W-1:0] T_TOGGLE = 4'd3;
  localparam logic [TYPE_W-1:0] T_STOP = 4'd4;
  localparam logic [TYPE_W-1:0] T_SEEK = 4'd5;
  localparam logic [TYPE_W-1:0] T_NEXT = 4'd6;
  localparam logic [TYPE_W-1:0] T_PREVKEY = 4'd9;
  localparam logic [TYPE_W-1:0] T_TICK = 4'd10;

  localparam logic [OUTC_W-1:0] OC_QUEUED = 4'd0;
  localparam logic [OUTC_W-1:0] OC_MERGED = 4'd1;
  localparam logic [OUTC_W-1:0] OC_EVICTED = 4'd2;
  localparam logic [OUTC_W-1:0] OC_DROPPED = 4'd3;
  localparam logic [OUTC_W-1:0] OC_POPPED = 4'd4;
  localparam logic [OUTC_W-1:0] OC_EMPTY = 4'd5;
  localparam logic [OUTC_W-1:0] OC_BEGUN = 4'd6;
  localparam logic [OUTC_W-1:0] OC_ENDED = 4'd7;
  localparam logic [OUTC_W-1:0] OC_IGNORED = 4'd8;

  typedef enum logic [1:0] {WSEL_COPY, WSEL_MERGE, WSEL_NEW} wsel_t;
  typedef enum logic [1:0] {RSEL_NONE, RSEL_STAMPS, RSEL_POP, RSEL_BEGIN} rsel_t;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [ARG_W-1:0] arg;
    logic [REP_W-1:0] rep;
    logic [STAMP_WIDTH-1:0] gen;
    logic [STAMP_WIDTH-1:0] del;
    logic [STAMP_WIDTH-1:0] life;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic wr_en;
    logic [IDX_W-1:0] wr_idx;
    wsel_t wr_sel;
    logic cnt_clear;
    logic cnt_set;
    logic [CNT_W-1:0] cnt_val;
    logic cnt_inc;
    logic pop;
    logic acc_en;
    logic res_en;
    rsel_t res_sel;
    logic [OUTC_W-1:0] res_outcome;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] item_cmd;
    logic [TYPE_W-1:0] item_type;
    logic [CNT_W-1:0] count;
    logic [TYPE_W-1:0] rd_kind;
    logic end_ok;
    logic out_free;
  } status_t;

  function automatic logic is_nav(input logic [TYPE_W-1:0] t);
    return (t >= T_NEXT) && (t <= T_PREVKEY);
  endfunction

  function automatic logic cancels(input logic [TYPE_W-1:0] inc,
                                   input logic [TYPE_W-1:0] act);
    logic r;
    r = 1'b0;
    if (inc == T_OPEN || inc == T_STOP) begin
      r = 1'b1;
    end else if (inc == T_SEEK) begin
      r = (act != T_OPEN);
    end else if (inc == T_PAUSE || inc == T_TOGGLE || is_nav(inc)) begin
      r = (act == T_TICK);
    end
    return r;
  endfunction

endpackage

@@ sv/ccq_datapath.sv @@
// Datapath of the command queue: slot memory, counters, active operation and result register.
module ccq_datapath (
  input  logic clk,
  input  logic rst,
  input  ccq_pkg::ctrl_t ctl,
  output ccq_pkg::status_t sts,
  input  logic [1:0] command,
  input  logic [ccq_pkg::TYPE_W-1:0] cmd_type,
  input  logic [ccq_pkg::ARG_W-1:0] argument,
  input  logic [ccq_pkg::REP_W-1:0] repetitions,
  input  logic [ccq_pkg::TAG_W-1:0] op_tag,
  output logic out_valid,
  input  logic out_stall,
  output logic result_valid,
  output logic [ccq_pkg::OUTC_W-1:0] outcome,
  output logic [ccq_pkg::TYPE_W-1:0] type_out,
  output logic [ccq_pkg::ARG_W-1:0] argument_out,
  output logic [ccq_pkg::REP_W-1:0] repeat_out,
  output logic [ccq_pkg::STAMP_WIDTH-1:0] generation_out,
  output logic [ccq_pkg::STAMP_WIDTH-1:0] delivery_epoch_out,
  output logic [ccq_pkg::STAMP_WIDTH-1:0] lifecycle_epoch_out,
  output logic cancel_flag,
  output logic [ccq_pkg::TAG_W-1:0] tag_out
);

  ccq_pkg::entry_t mem [ccq_pkg::QUEUE_DEPTH];
  ccq_pkg::entry_t rdata;
  ccq_pkg::entry_t wdata;

  logic [ccq_pkg::IDX_W-1:0] head;
  logic [ccq_pkg::CNT_W-1:0] count;
  logic [ccq_pkg::STAMP_WIDTH-1:0] gen_cnt;
  logic [ccq_pkg::STAMP_WIDTH-1:0] del_cnt;
  logic [ccq_pkg::STAMP_WIDTH-1:0] life_cnt;
  logic active_valid;
  logic [ccq_pkg::TYPE_W-1:0] active_type;
  logic [ccq_pkg::TAG_W-1:0] active_tag;
  logic [ccq_pkg::TAG_W-1:0] tag_cnt;

  logic [1:0] item_cmd;
  logic [ccq_pkg::TYPE_W-1:0] item_type;
  logic [ccq_pkg::ARG_W-1:0] item_arg;
  logic [ccq_pkg::REP_W-1:0] item_rep;
  logic item_cancel;
  logic end_ok;
  logic acc;

  logic stamp_ok;
  logic [ccq_pkg::REP_W-1:0] rep_norm;
  logic [ccq_pkg::REP_W:0] rep_sum;
  logic [ccq_pkg::REP_W-1:0] rep_merged;

  assign stamp_ok = (command == ccq_pkg::CMD_ENQUEUE) && (cmd_type <= ccq_pkg::T_TICK);

  always_comb begin
    rep_norm = ccq_pkg::REP_W'(1);
    if (ccq_pkg::is_nav(cmd_type)) begin
      if (repetitions == '0) begin
        rep_norm = ccq_pkg::REP_W'(1);
      end else if (repetitions > ccq_pkg::MAX_REP) begin
        rep_norm = ccq_pkg::MAX_REP;
      end else begin
        rep_norm = repetitions;
      end
    end
  end

  assign rep_sum = {1'b0, rdata.rep} + {1'b0, item_rep};
  assign rep_merged = (rep_sum > {1'b0, ccq_pkg::MAX_REP}) ? ccq_pkg::MAX_REP
                                                            : rep_sum[ccq_pkg::REP_W-1:0];

  always_comb begin
    unique case (ctl.wr_sel)
      ccq_pkg::WSEL_COPY: wdata = rdata;
      ccq_pkg::WSEL_MERGE: begin
        wdata = rdata;
        wdata.rep = rep_merged;
        wdata.gen = gen_cnt;
        wdata.del = del_cnt;
      end
      default: begin
        wdata.kind = item_type;
        wdata.arg = item_arg;
        wdata.rep = item_rep;
        wdata.gen = gen_cnt;
        wdata.del = del_cnt;
        wdata.life = life_cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[head + ctl.wr_idx] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[head + ctl.rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
      gen_cnt <= '0;
      del_cnt <= '0;
      life_cnt <= '0;
      active_valid <= 1'b0;
      active_type <= '0;
      active_tag <= '0;
      tag_cnt <= '0;
    end else begin
      if (ctl.load) begin
        if (stamp_ok) begin
          gen_cnt <= gen_cnt + 1'b1;
          if (cmd_type == ccq_pkg::T_OPEN || cmd_type == ccq_pkg::T_STOP ||
              cmd_type == ccq_pkg::T_SEEK || ccq_pkg::is_nav(cmd_type)) begin
            del_cnt <= del_cnt + 1'b1;
          end
          if (cmd_type == ccq_pkg::T_OPEN) begin
            life_cnt <= life_cnt + 1'b1;
          end
        end
        if (command == ccq_pkg::CMD_BEGIN) begin
          tag_cnt <= tag_cnt + 1'b1;
          active_valid <= 1'b1;
          active_type <= cmd_type;
          active_tag <= tag_cnt + 1'b1;
        end
        if (command == ccq_pkg::CMD_END && active_valid && op_tag == active_tag) begin
          active_valid <= 1'b0;
          active_type <= '0;
        end
      end
      if (ctl.cnt_clear) begin
        count <= '0;
      end else if (ctl.cnt_set) begin
        count <= ctl.cnt_val;
      end else if (ctl.cnt_inc) begin
        count <= count + 1'b1;
      end else if (ctl.pop) begin
        count <= count - 1'b1;
        head <= head + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_cmd <= command;
      item_type <= cmd_type;
      item_arg <= (cmd_type == ccq_pkg::T_OPEN || cmd_type == ccq_pkg::T_SEEK) ? argument : '0;
      item_rep <= rep_norm;
      item_cancel <= active_valid && ccq_pkg::cancels(cmd_type, active_type);
      end_ok <= active_valid && (op_tag == active_tag);
      acc <= 1'b0;
    end else if (ctl.acc_en) begin
      acc <= acc | ccq_pkg::cancels(rdata.kind, item_type);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_en) begin
      outcome <= ctl.res_outcome;
      result_valid <= (ctl.res_sel == ccq_pkg::RSEL_POP);
      type_out <= '0;
      argument_out <= '0;
      repeat_out <= '0;
      generation_out <= '0;
      delivery_epoch_out <= '0;
      lifecycle_epoch_out <= '0;
      cancel_flag <= 1'b0;
      tag_out <= '0;
      unique case (ctl.res_sel)
        ccq_pkg::RSEL_STAMPS: begin
          generation_out <= gen_cnt;
          delivery_epoch_out <= del_cnt;
          lifecycle_epoch_out <= life_cnt;
          cancel_flag <= item_cancel;
        end
        ccq_pkg::RSEL_POP: begin
          type_out <= rdata.kind;
          argument_out <= rdata.arg;
          repeat_out <= rdata.rep;
          generation_out <= rdata.gen;
          delivery_epoch_out <= rdata.del;
          lifecycle_epoch_out <= rdata.life;
        end
        ccq_pkg::RSEL_BEGIN: begin
          cancel_flag <= acc;
          tag_out <= active_tag;
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.item_cmd = item_cmd;
  assign sts.item_type = item_type;
  assign sts.count = count;
  assign sts.rd_kind = rdata.kind;
  assign sts.end_ok = end_ok;
  assign sts.out_free = !out_valid || !out_stall;

endmodule

@@ sv/ccq_ctrl.sv @@
// Sequencer of the command queue: dispatch, filtering passes, eviction, merge and scans.
module ccq_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  ccq_pkg::status_t sts,
  output ccq_pkg::ctrl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_FILT_RD, S_FILT_WR, S_MERGE_CHK, S_APPEND,
    S_EVICT_RD, S_EVICT_CHK, S_POP, S_SCAN_RD, S_SCAN_CHK, S_DONE
  } state_t;

  typedef enum logic [1:0] {F_SEEKNAV, F_PLAYPAUSE, F_INDEX} fmode_t;

  state_t state, state_next;
  fmode_t fmode, fmode_next;
  logic [ccq_pkg::CNT_W-1:0] r, r_next;
  logic [ccq_pkg::CNT_W-1:0] w, w_next;
  logic [ccq_pkg::CNT_W-1:0] evict_idx, evict_idx_next;
  logic evicted, evicted_next;
  logic [ccq_pkg::OUTC_W-1:0] oc, oc_next;
  ccq_pkg::rsel_t rsel, rsel_next;
  logic drop;
  logic [ccq_pkg::CNT_W-1:0] last;

  assign in_stall = (state != S_IDLE);
  assign last = sts.count - 1'b1;

  always_comb begin
    unique case (fmode)
      F_SEEKNAV: drop = (sts.rd_kind == ccq_pkg::T_SEEK) || ccq_pkg::is_nav(sts.rd_kind);
      F_PLAYPAUSE: drop = (sts.rd_kind == ccq_pkg::T_PLAY) || (sts.rd_kind == ccq_pkg::T_PAUSE);
      default: drop = (r == evict_idx);
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.rd_idx = r[ccq_pkg::IDX_W-1:0];
    ctl.wr_idx = w[ccq_pkg::IDX_W-1:0];
    ctl.wr_sel = ccq_pkg::WSEL_COPY;
    ctl.res_sel = rsel;
    ctl.res_outcome = oc;
    state_next = state;
    fmode_next = fmode;
    r_next = r;
    w_next = w;
    evict_idx_next = evict_idx;
    evicted_next = evicted;
    oc_next = oc;
    rsel_next = rsel;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        r_next = '0;
        w_next = '0;
        evicted_next = 1'b0;
        unique case (sts.item_cmd)
          ccq_pkg::CMD_ENQUEUE: begin
            rsel_next = ccq_pkg::RSEL_STAMPS;
            if (sts.item_type > ccq_pkg::T_TICK) begin
              oc_next = ccq_pkg::OC_DROPPED;
              rsel_next = ccq_pkg::RSEL_NONE;
              state_next = S_DONE;
            end else if (sts.item_type == ccq_pkg::T_OPEN ||
                         sts.item_type == ccq_pkg::T_STOP) begin
              ctl.cnt_clear = 1'b1;
              state_next = S_APPEND;
            end else if (sts.item_type == ccq_pkg::T_SEEK) begin
              fmode_next = F_SEEKNAV;
              state_next = S_FILT_RD;
            end else if (sts.item_type == ccq_pkg::T_PLAY ||
                         sts.item_type == ccq_pkg::T_PAUSE) begin
              fmode_next = F_PLAYPAUSE;
              state_next = S_FILT_RD;
            end else if (ccq_pkg::is_nav(sts.item_type) && sts.count != '0) begin
              ctl.rd_en = 1'b1;
              ctl.rd_idx = last[ccq_pkg::IDX_W-1:0];
              state_next = S_MERGE_CHK;
            end else begin
              state_next = S_APPEND;
            end
          end
          ccq_pkg::CMD_POP: begin
            if (sts.count == '0) begin
              oc_next = ccq_pkg::OC_EMPTY;
              rsel_next = ccq_pkg::RSEL_NONE;
              state_next = S_DONE;
            end else begin
              ctl.rd_en = 1'b1;
              ctl.rd_idx = '0;
              state_next = S_POP;
            end
          end
          ccq_pkg::CMD_BEGIN: begin
            oc_next = ccq_pkg::OC_BEGUN;
            rsel_next = ccq_pkg::RSEL_BEGIN;
            state_next = S_SCAN_RD;
          end
          default: begin
            oc_next = sts.end_ok ? ccq_pkg::OC_ENDED : ccq_pkg::OC_IGNORED;
            rsel_next = ccq_pkg::RSEL_NONE;
            state_next = S_DONE;
          end
        endcase
      end
      S_FILT_RD: begin
        if (r == sts.count) begin
          ctl.cnt_set = 1'b1;
          ctl.cnt_val = w;
          state_next = S_APPEND;
        end else begin
          ctl.rd_en = 1'b1;
          state_next = S_FILT_WR;
        end
      end
      S_FILT_WR: begin
        if (!drop) begin
          ctl.wr_en = (w != r);
          w_next = w + 1'b1;
        end
        r_next = r + 1'b1;
        state_next = S_FILT_RD;
      end
      S_MERGE_CHK: begin
        if (sts.rd_kind == sts.item_type) begin
          ctl.wr_en = 1'b1;
          ctl.wr_idx = last[ccq_pkg::IDX_W-1:0];
          ctl.wr_sel = ccq_pkg::WSEL_MERGE;
          oc_next = ccq_pkg::OC_MERGED;
          state_next = S_DONE;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        if (sts.count == ccq_pkg::CNT_W'(ccq_pkg::QUEUE_DEPTH)) begin
          r_next = '0;
          state_next = S_EVICT_RD;
        end else begin
          ctl.wr_en = 1'b1;
          ctl.wr_idx = sts.count[ccq_pkg::IDX_W-1:0];
          ctl.wr_sel = ccq_pkg::WSEL_NEW;
          ctl.cnt_inc = 1'b1;
          oc_next = evicted ? ccq_pkg::OC_EVICTED : ccq_pkg::OC_QUEUED;
          state_next = S_DONE;
        end
      end
      S_EVICT_RD: begin
        if (r == sts.count) begin
          oc_next = ccq_pkg::OC_DROPPED;
          state_next = S_DONE;
        end else begin
          ctl.rd_en = 1'b1;
          state_next = S_EVICT_CHK;
        end
      end
      S_EVICT_CHK: begin
        if (sts.rd_kind != ccq_pkg::T_OPEN && sts.rd_kind != ccq_pkg::T_STOP) begin
          evict_idx_next = r;
          fmode_next = F_INDEX;
          evicted_next = 1'b1;
          r_next = '0;
          w_next = '0;
          state_next = S_FILT_RD;
        end else begin
          r_next = r + 1'b1;
          state_next = S_EVICT_RD;
        end
      end
      S_POP: begin
        ctl.pop = 1'b1;
        oc_next = ccq_pkg::OC_POPPED;
        rsel_next = ccq_pkg::RSEL_POP;
        state_next = S_DONE;
      end
      S_SCAN_RD: begin
        if (r == sts.count) begin
          state_next = S_DONE;
        end else begin
          ctl.rd_en = 1'b1;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        ctl.acc_en = 1'b1;
        r_next = r + 1'b1;
        state_next = S_SCAN_RD;
      end
      default: begin
        if (sts.out_free) begin
          ctl.res_en = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fmode <= F_SEEKNAV;
      r <= '0;
      w <= '0;
      evict_idx <= '0;
      evicted <= 1'b0;
      oc <= ccq_pkg::OC_QUEUED;
      rsel <= ccq_pkg::RSEL_NONE;
    end else begin
      state <= state_next;
      fmode <= fmode_next;
      r <= r_next;
      w <= w_next;
      evict_idx <= evict_idx_next;
      evicted <= evicted_next;
      oc <= oc_next;
      rsel <= rsel_next;
    end
  end

endmodule

@@ sv/coalescing_command_queue_core.sv @@
// Top level of the coalescing command queue: sequencer plus datapath.
// Usage: one request enters on in_valid/in_stall and produces exactly one result
// on out_valid/out_stall. Requests are processed one at a time; in_stall is low
// only while the sequencer is idle.
// Seek, play and pause enqueues run a filtering pass over the queue, and a begin
// scans the queue. An enqueue into a full queue adds an eviction search and a
// compaction pass. The slot memory is read once per entry visited.
// The slots form a circular buffer, so a pop only advances the head pointer.
// Reset clears the entry count, the stamp and tag counters and the active
// operation; slot contents need no clearing.
// When the receiver stalls, the result stays in the output register and the
// next request is still accepted; its result waits in the sequencer until the
// output register frees.
module coalescing_command_queue_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] command,
  input  logic [ccq_pkg::TYPE_W-1:0] cmd_type,
  input  logic [ccq_pkg::ARG_W-1:0] argument,
  input  logic [ccq_pkg::REP_W-1:0] repetitions,
  input  logic [ccq_pkg::TAG_W-1:0] op_tag,
  output logic out_valid,
  input  logic out_stall,
  output logic result_valid,
  output logic [ccq_pkg::OUTC_W-1:0] outcome,
  output logic [ccq_pkg::TYPE_W-1:0] type_out,
  output logic [ccq_pkg::ARG_W-1:0] argument_out,
  output logic [ccq_pkg::REP_W-1:0] repeat_out,
  output logic [ccq_pkg::STAMP_WIDTH-1:0] generation_out,
  output logic [ccq_pkg::STAMP_WIDTH-1:0] delivery_epoch_out,
  output logic [ccq_pkg::STAMP_WIDTH-1:0] lifecycle_epoch_out,
  output logic cancel_flag,
  output logic [ccq_pkg::TAG_W-1:0] tag_out
);

  ccq_pkg::ctrl_t ctl;
  ccq_pkg::status_t sts;

  ccq_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts(sts),
    .ctl(ctl)
  );

  ccq_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .sts(sts),
    .command(command),
    .cmd_type(cmd_type),
    .argument(argument),
    .repetitions(repetitions),
    .op_tag(op_tag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_valid(result_valid),
    .outcome(outcome),
    .type_out(type_out),
    .argument_out(argument_out),
    .repeat_out(repeat_out),
    .generation_out(generation_out),
    .delivery_epoch_out(delivery_epoch_out),
    .lifecycle_epoch_out(lifecycle_epoch_out),
    .cancel_flag(cancel_flag),
    .tag_out(tag_out)
  );

endmodule
